>>> hw/rtl/fcsb_pkg.sv
`default_nettype none

package fcsb_pkg;

    // Plane registers
    localparam int PLANE_COUNT = 6;
    localparam int IDX_W       = 3;
    localparam int ADDR_W      = 6;
    localparam int IDX_LSB     = 3;
    localparam int DATA_W      = 64;

    // Fixed-point widths: Q1.14 * Q8.8 products land in Q.22
    localparam int COORD_W   = 16;
    localparam int OFF_W     = 17;
    localparam int PROD_W    = 32;
    localparam int PAIR_W    = 33;
    localparam int SUM_W     = 34;
    localparam int OFF_SHIFT = 14;
    localparam int AXES      = 3;

    // Operation codes
    localparam logic OP_SPHERE = 1'b0;
    localparam logic OP_BOX    = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic   operation;
        coord_t center_x;
        coord_t center_y;
        coord_t center_z;
        coord_t radius;
        coord_t box_min_x;
        coord_t box_min_y;
        coord_t box_min_z;
        coord_t box_max_x;
        coord_t box_max_y;
        coord_t box_max_z;
    } req_t;

    typedef struct packed {
        logic adv_prod;
        logic adv_sum;
    } stage_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/fcsb_req_if.sv
`default_nettype none

interface fcsb_req_if;
    logic           valid;
    logic           ready;
    fcsb_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fcsb_rsp_if.sv
`default_nettype none

interface fcsb_rsp_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, output visible, input ready);
    modport sink (input valid, input visible, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fcsb_plane.sv
`default_nettype none

module fcsb_plane (
    input  wire logic                          clk,
    input  wire fcsb_pkg::stage_ctrl_t         ctrl,
    input  wire logic [fcsb_pkg::DATA_W-1:0]   plane,
    input  wire fcsb_pkg::req_t                item,
    output logic                               below
);

    fcsb_pkg::coord_t                      nrm [fcsb_pkg::AXES];
    fcsb_pkg::coord_t                      pt  [fcsb_pkg::AXES];
    fcsb_pkg::coord_t                      bmin [fcsb_pkg::AXES];
    fcsb_pkg::coord_t                      bmax [fcsb_pkg::AXES];
    fcsb_pkg::coord_t                      ctr  [fcsb_pkg::AXES];
    fcsb_pkg::coord_t                      ofs;
    logic signed [fcsb_pkg::OFF_W-1:0]     rsum;
    logic signed [fcsb_pkg::PROD_W-1:0]    prod_next [fcsb_pkg::AXES];
    logic signed [fcsb_pkg::PROD_W-1:0]    prod_reg  [fcsb_pkg::AXES];
    logic signed [fcsb_pkg::PAIR_W-1:0]    off_next;
    logic signed [fcsb_pkg::PAIR_W-1:0]    off_reg;
    logic signed [fcsb_pkg::PAIR_W-1:0]    pair_a_next;
    logic signed [fcsb_pkg::PAIR_W-1:0]    pair_b_next;
    logic signed [fcsb_pkg::PAIR_W-1:0]    pair_a_reg;
    logic signed [fcsb_pkg::PAIR_W-1:0]    pair_b_reg;
    logic signed [fcsb_pkg::SUM_W-1:0]     total;

    // Unpack the plane and the object
    always_comb
    begin
        nrm[0]  = plane[63:48];
        nrm[1]  = plane[47:32];
        nrm[2]  = plane[31:16];
        ofs     = plane[15:0];
        ctr[0]  = item.center_x;
        ctr[1]  = item.center_y;
        ctr[2]  = item.center_z;
        bmin[0] = item.box_min_x;
        bmin[1] = item.box_min_y;
        bmin[2] = item.box_min_z;
        bmax[0] = item.box_max_x;
        bmax[1] = item.box_max_y;
        bmax[2] = item.box_max_z;
    end

    // Pick the test point and multiply by the normal
    always_comb
    begin
        for (int k = 0; k < fcsb_pkg::AXES; k++)
        begin
            if (item.operation == fcsb_pkg::OP_SPHERE)
            begin
                pt[k] = ctr[k];
            end
            else
            begin
                // positive-vertex pick: max corner where the normal is not negative
                pt[k] = nrm[k][fcsb_pkg::COORD_W-1] ? bmin[k] : bmax[k];
            end
            prod_next[k] = fcsb_pkg::PROD_W'(nrm[k]) * fcsb_pkg::PROD_W'(pt[k]);
        end
    end

    // Fold the radius into the offset for the sphere test
    always_comb
    begin
        rsum = fcsb_pkg::OFF_W'(ofs)
             + ((item.operation == fcsb_pkg::OP_SPHERE)
                ? fcsb_pkg::OFF_W'(item.radius) : fcsb_pkg::OFF_W'(0));
        off_next = fcsb_pkg::PAIR_W'(rsum) <<< fcsb_pkg::OFF_SHIFT;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv_prod)
        begin
            prod_reg <= prod_next;
            off_reg  <= off_next;
        end
    end

    // Add in pairs
    always_comb
    begin
        pair_a_next = fcsb_pkg::PAIR_W'(prod_reg[0]) + fcsb_pkg::PAIR_W'(prod_reg[1]);
        pair_b_next = fcsb_pkg::PAIR_W'(prod_reg[2]) + off_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv_sum)
        begin
            pair_a_reg <= pair_a_next;
            pair_b_reg <= pair_b_next;
        end
    end

    // Final sum: the object lies outside when the signed distance is negative
    always_comb
    begin
        total = fcsb_pkg::SUM_W'(pair_a_reg) + fcsb_pkg::SUM_W'(pair_b_reg);
        below = total[fcsb_pkg::SUM_W-1];
    end

endmodule

`default_nettype wire

>>> hw/rtl/frustum_cull_sphere_box_test.sv
// Frustum culling of spheres and axis aligned boxes against six planes.
// Channels: req carries one object per request (operation selects the
// sphere test or the box test); rsp returns one visible bit per request,
// in request order. Both use valid/ready; a request moves when both are high.
// The six planes are 64-bit registers on the APB port at byte address 8*i
// (nx, ny, nz Q1.14 and offset Q8.8); write them only while no request is
// in flight. Writes above plane 5 are dropped.
// A request passes the input register, the multiply register, the pair add
// register and the final add into the output register before it shows on
// rsp. Throughput: one request per cycle while rsp does not stall, set by
// the four-stage pipeline with all six planes evaluated side by side
// (18 multipliers).
// Reset clears all planes to zero and empties the pipeline.
// When rsp stalls, the pipeline fills its empty stages and then holds;
// req.ready drops only when every stage holds a request, so nothing is
// lost or repeated.
`default_nettype none

module frustum_cull_sphere_box_test (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [fcsb_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [fcsb_pkg::DATA_W-1:0]       pwdata,
    output logic      [fcsb_pkg::DATA_W-1:0]       prdata,
    output logic                                   pready,
    fcsb_req_if.sink                               req,
    fcsb_rsp_if.source                             rsp
);

    logic [fcsb_pkg::DATA_W-1:0]  plane_reg [fcsb_pkg::PLANE_COUNT];
    logic [fcsb_pkg::IDX_W-1:0]   reg_idx;
    logic                         wr_en;

    fcsb_pkg::req_t               item_next;
    fcsb_pkg::req_t               item_reg;
    logic                         v1_next, v1_reg;
    logic                         v2_next, v2_reg;
    logic                         v3_next, v3_reg;
    logic                         v4_next, v4_reg;
    logic                         kill2_next, kill2_reg;
    logic                         kill3_next, kill3_reg;
    logic                         vis_next, vis_reg;
    logic                         rdy1, rdy2, rdy3, rdy4;
    fcsb_pkg::stage_ctrl_t        ctrl;
    logic [fcsb_pkg::PLANE_COUNT-1:0] below;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[fcsb_pkg::ADDR_W-1:fcsb_pkg::IDX_LSB];
    assign wr_en   = psel && penable && pwrite
                   && (reg_idx < fcsb_pkg::IDX_W'(fcsb_pkg::PLANE_COUNT));

    always_comb
    begin
        if (reg_idx < fcsb_pkg::IDX_W'(fcsb_pkg::PLANE_COUNT))
        begin
            prdata = plane_reg[reg_idx];
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fcsb_pkg::PLANE_COUNT; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            plane_reg[reg_idx] <= pwdata;
        end
    end

    // Stage readiness: a stage takes new data when empty or draining
    always_comb
    begin
        rdy4 = !v4_reg || rsp.ready;
        rdy3 = !v3_reg || rdy4;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;
        ctrl.adv_prod = v1_reg && rdy2;
        ctrl.adv_sum  = v2_reg && rdy3;
    end

    assign req.ready = rdy1;

    // Advance valid bits and flags
    always_comb
    begin
        v1_next    = rdy1 ? req.valid : v1_reg;
        v2_next    = rdy2 ? v1_reg : v2_reg;
        v3_next    = rdy3 ? v2_reg : v3_reg;
        v4_next    = rdy4 ? v3_reg : v4_reg;
        item_next  = (rdy1 && req.valid) ? req.data : item_reg;
        kill2_next = ctrl.adv_prod
                   ? ((item_reg.operation == fcsb_pkg::OP_SPHERE)
                      && item_reg.radius[fcsb_pkg::COORD_W-1])
                   : kill2_reg;
        kill3_next = ctrl.adv_sum ? kill2_reg : kill3_reg;
        vis_next   = (rdy4 && v3_reg) ? (!kill3_reg && (below == '0)) : vis_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        kill2_reg <= kill2_next;
        kill3_reg <= kill3_next;
        vis_reg   <= vis_next;
    end

    // One evaluator per plane
    for (genvar p = 0; p < fcsb_pkg::PLANE_COUNT; p++)
    begin : g_plane
        fcsb_plane u_plane (
            .clk   (clk),
            .ctrl  (ctrl),
            .plane (plane_reg[p]),
            .item  (item_reg),
            .below (below[p])
        );
    end

    assign rsp.valid   = v4_reg;
    assign rsp.visible = vis_reg;

    // A sphere with negative radius always comes out not visible
    a_neg_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && kill3_reg && rdy4) |=> (rsp.valid && !rsp.visible))
        else $error("negative radius sphere reported visible");

    // Input back-pressure only when every stage is full and the output stalls
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !req.ready) |-> (v2_reg && v3_reg && v4_reg && !rsp.ready))
        else $error("input stalled with a bubble in the pipeline");

    // A request leaving stage three reaches the output register
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && rdy4) |=> rsp.valid)
        else $error("request dropped before the output register");

endmodule

`default_nettype wire
